// File: sv/ordered_key_value_table_assert.svh
// Assertion helpers for the key/value table.
`ifndef ORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define OKVT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/okvt_pkg.sv
package okvt_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 5;

  // Operation codes
  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_LOOKUP  = 3'd1;
  localparam logic [2:0] KIND_REMOVE  = 3'd2;
  localparam logic [2:0] KIND_REWIND  = 3'd3;
  localparam logic [2:0] KIND_ADVANCE = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_UPDATED  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

endpackage

// File: sv/ordered_key_value_table.sv
// Ordered key/value table with an in-order iterator.
// Input channel: in_tuser carries the operation (insert, lookup, remove,
// rewind, advance), in_tdata the signed key and the value word. One beat in
// gives exactly one beat out on the result channel: status in out_tuser,
// lookup value, entry count and the iterator's entry in out_tdata.
// Entries live in a small single-port-read memory that a sequencer walks one
// entry per cycle, comparing against one shared key comparator. A key search
// reads the held entries in order and stops at the first match; a remove that
// hits then slides the later entries down at one entry per cycle. Rewind,
// advance and unused kinds skip the search and go straight to the iterator
// fetch; every kind ends in the output register. The sequencer returns to idle
// as the result is registered, and the next beat can be taken from there.
// in_tready is high only while the sequencer is idle; the next beat is taken
// while a finished result still waits in the output register.
// When the receiver stalls, the result is held in out_tdata/out_tuser and a
// following operation finishes its work, then waits for the register to free.
// Reset (rst_n low, synchronous) empties the table and puts the iterator at
// end; no clearing pass is needed, so the block is ready right after reset.
module ordered_key_value_table (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: key [31:0], value [63:32]
  input  logic [63:0]  in_tdata,
  // in_tuser: kind [2:0]
  input  logic [2:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: found_value [31:0], entry_count [36:32], iter_key [68:37],
  //            iter_value [100:69], iter_end [101], zero pad [103:102]
  output logic [103:0] out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready
);

  `include "ordered_key_value_table_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam okvt_pkg::cnt_t FULL_CNT = okvt_pkg::CNT_W'(okvt_pkg::ENTRIES);
  localparam okvt_pkg::cnt_t ONE_CNT  = okvt_pkg::CNT_W'(1);

  // Entry storage
  logic [31:0] key_mem [okvt_pkg::ENTRIES];
  logic [31:0] val_mem [okvt_pkg::ENTRIES];

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [31:0]     val_r, val_nxt;
  okvt_pkg::cnt_t  idx_r, idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  okvt_pkg::cnt_t  rd_idx_r, rd_idx_nxt;
  logic            hit_r, hit_nxt;
  okvt_pkg::cnt_t  match_r, match_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [31:0]     found_r, found_nxt;
  okvt_pkg::cnt_t  total_r, total_nxt;
  okvt_pkg::cnt_t  iter_r, iter_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [103:0]    out_data_r, out_data_nxt;
  logic [1:0]      out_user_r, out_user_nxt;

  // Memory port controls
  logic            rd_en;
  okvt_pkg::idx_t  rd_addr;
  logic [31:0]     rd_key_r, rd_val_r;
  logic            wr_en;
  okvt_pkg::idx_t  wr_addr;
  logic [31:0]     wr_key, wr_val;

  logic            in_fire;
  logic            out_free;
  logic            iter_none;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign iter_none = (iter_r == '0);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    match_nxt     = match_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    total_nxt     = total_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_key        = key_r;
    wr_val        = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_tuser;
          key_nxt    = in_tdata[31:0];
          val_nxt    = in_tdata[63:32];
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          status_nxt = okvt_pkg::ST_DONE;
          found_nxt  = '0;
          case (in_tuser)
            okvt_pkg::KIND_INSERT, okvt_pkg::KIND_LOOKUP, okvt_pkg::KIND_REMOVE: begin
              state_nxt = (total_r == '0) ? S_ACT : S_SCAN;
            end
            okvt_pkg::KIND_REWIND: begin
              iter_nxt  = (total_r != '0) ? ONE_CNT : '0;
              state_nxt = S_ITER;
            end
            okvt_pkg::KIND_ADVANCE: begin
              if (!iter_none) begin
                iter_nxt = (iter_r < total_r) ? iter_r + ONE_CNT : '0;
              end
              state_nxt = S_ITER;
            end
            default: begin
              state_nxt = S_ITER;
            end
          endcase
        end
      end

      // One read issued and one compare per cycle
      S_SCAN: begin
        if (idx_r < total_r) begin
          rd_en      = 1'b1;
          rd_addr    = idx_r[okvt_pkg::IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + ONE_CNT;
        end
        if (rd_vld_r) begin
          if (rd_key_r == key_r) begin
            hit_nxt   = 1'b1;
            match_nxt = rd_idx_r;
            found_nxt = rd_val_r;
            state_nxt = S_ACT;
          end else if (rd_idx_r == total_r - ONE_CNT) begin
            state_nxt = S_ACT;
          end
        end
      end

      S_ACT: begin
        state_nxt = S_ITER;
        case (kind_r)
          okvt_pkg::KIND_INSERT: begin
            found_nxt = '0;
            if (hit_r) begin
              wr_en      = 1'b1;
              wr_addr    = match_r[okvt_pkg::IDX_W-1:0];
              status_nxt = okvt_pkg::ST_UPDATED;
            end else if (total_r == FULL_CNT) begin
              status_nxt = okvt_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = total_r[okvt_pkg::IDX_W-1:0];
              total_nxt = total_r + ONE_CNT;
            end
          end
          okvt_pkg::KIND_LOOKUP: begin
            if (!hit_r) begin
              status_nxt = okvt_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            found_nxt = '0;
            if (hit_r) begin
              idx_nxt   = match_r + ONE_CNT;
              state_nxt = S_SHIFT;
            end else begin
              status_nxt = okvt_pkg::ST_NOTFOUND;
            end
          end
        endcase
      end

      // Slide later entries down one slot: read i+1, write i next cycle
      S_SHIFT: begin
        if (idx_r < total_r) begin
          rd_en      = 1'b1;
          rd_addr    = idx_r[okvt_pkg::IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = idx_r + ONE_CNT;
        end
        if (rd_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = okvt_pkg::IDX_W'(rd_idx_r - ONE_CNT);
          wr_key  = rd_key_r;
          wr_val  = rd_val_r;
        end
        if (!(idx_r < total_r) && !rd_vld_r) begin
          total_nxt = total_r - ONE_CNT;
          if (!iter_none) begin
            if (match_r + ONE_CNT < iter_r) begin
              iter_nxt = iter_r - ONE_CNT;
            end else if (iter_r > total_r - ONE_CNT) begin
              iter_nxt = '0;
            end
          end
          state_nxt = S_ITER;
        end
      end

      // Fetch the iterator's entry
      S_ITER: begin
        if (!iter_none) begin
          rd_en   = 1'b1;
          rd_addr = okvt_pkg::IDX_W'(iter_r - ONE_CNT);
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {2'b00,
                           iter_none,
                           iter_none ? 32'd0 : rd_val_r,
                           iter_none ? 32'd0 : rd_key_r,
                           total_r,
                           found_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      iter_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      iter_r      <= iter_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_r      <= hit_nxt;
    match_r    <= match_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // Checks
  `OKVT_ASSERT_ALWAYS(a_total_bound, total_r <= FULL_CNT, "entry count exceeds table size")
  `OKVT_ASSERT_ALWAYS(a_iter_bound, iter_r <= total_r, "iterator beyond last entry")
  `OKVT_ASSERT_NEXT(a_busy_after_accept, in_fire, state_r != S_IDLE, "sequencer idle after accept")
  `OKVT_ASSERT_ALWAYS(a_shift_in_range, !(state_r == S_SHIFT && wr_en) || (rd_idx_r < total_r && rd_idx_r > match_r), "slide write outside held entries")

endmodule
